// ===== sv/bli_pkg.sv =====
package bli_pkg;

  // Operation codes carried by the operation field.
  typedef enum logic [1:0] {
    OP_FOOT   = 2'd0,
    OP_CROUCH = 2'd1,
    OP_SHIFT  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Register indexes of the configuration port.
  localparam logic REG_LINK   = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  localparam logic [11:0] LINK_RESET   = 12'd1280;
  localparam logic [9:0]  OFFSET_RESET = 10'd48;

  // Square root datapath: radicands are squared lengths shifted left by 32.
  localparam int RAD_W      = 60;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int SQRT_STEPS = ROOT_W;

  // CORDIC vectors and Q30 angle accumulator.
  localparam int VEC_W     = 34;
  localparam int ANG_W     = 33;
  localparam int VEC_SHIFT = 16;
  localparam int ATAN_LEN  = 24;

  localparam logic signed [VEC_W-1:0] UNIT = VEC_W'(65536);

  localparam logic [ANG_W-1:0] ATAN_Q30 [ATAN_LEN] = '{
    33'd843314857, 33'd497837829, 33'd263043837, 33'd133525159,
    33'd67021687,  33'd33543516,  33'd16775851,  33'd8388437,
    33'd4194283,   33'd2097149,   33'd1048576,   33'd524288,
    33'd262144,    33'd131072,    33'd65536,     33'd32768,
    33'd16384,     33'd8192,      33'd4096,      33'd2048,
    33'd1024,      33'd512,       33'd256,       33'd128
  };

  // Request sideband that travels alongside the square root cells.
  typedef struct packed {
    op_e                      op;
    logic                     dpos;
    logic                     ok;
    logic signed [VEC_W-1:0]  a0;
    logic signed [VEC_W-1:0]  b0;
    logic signed [VEC_W-1:0]  b1;
  } side_t;

  // Flags that travel alongside the CORDIC cells.
  typedef struct packed {
    op_e  op;
    logic dpos;
    logic ok;
  } flag_t;

endpackage

// ===== sv/bli_sqrt_cell.sv =====
module bli_sqrt_cell (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [bli_pkg::RAD_W-1:0]  rad_i,
  input  logic [bli_pkg::REM_W-1:0]  rem_i,
  input  logic [bli_pkg::ROOT_W-1:0] root_i,
  output logic [bli_pkg::RAD_W-1:0]  rad_o,
  output logic [bli_pkg::REM_W-1:0]  rem_o,
  output logic [bli_pkg::ROOT_W-1:0] root_o
);
  import bli_pkg::*;

  logic [REM_W-1:0] shifted;
  logic [REM_W-1:0] trial;
  logic             take;

  // One restoring step: bring down two radicand bits, try root*4+1.
  assign shifted = {rem_i[REM_W-3:0], rad_i[RAD_W-1 -: 2]};
  assign trial   = REM_W'({root_i, 2'b01});
  assign take    = shifted >= trial;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= {rad_i[RAD_W-3:0], 2'b00};
      rem_o  <= take ? shifted - trial : shifted;
      root_o <= {root_i[ROOT_W-2:0], take};
    end
  end

endmodule

// ===== sv/bli_cordic_cell.sv =====
module bli_cordic_cell #(
  parameter int                        SHIFT = 0,
  parameter logic [bli_pkg::ANG_W-1:0] ANGLE = '0
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [bli_pkg::VEC_W-1:0] a_i,
  input  logic signed [bli_pkg::VEC_W-1:0] b_i,
  input  logic signed [bli_pkg::ANG_W-1:0] z_i,
  output logic signed [bli_pkg::VEC_W-1:0] a_o,
  output logic signed [bli_pkg::VEC_W-1:0] b_o,
  output logic signed [bli_pkg::ANG_W-1:0] z_o
);
  import bli_pkg::*;

  logic signed [VEC_W-1:0] da;
  logic signed [VEC_W-1:0] db;

  assign da = a_i >>> SHIFT;
  assign db = b_i >>> SHIFT;

  // Vectoring rotation drives b toward zero and accumulates the angle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!b_i[VEC_W-1]) begin
        a_o <= a_i + db;
        b_o <= b_i - da;
        z_o <= z_i + $signed(ANGLE);
      end else begin
        a_o <= a_i - db;
        b_o <= b_i + da;
        z_o <= z_i - $signed(ANGLE);
      end
    end
  end

endmodule

// ===== sv/biped_leg_inverse_kinematics.sv =====
// Throughput: one request per cycle while the output is not stalled; three front
// stages, one square root cell per root bit (30) and one CORDIC cell per iteration,
// all advancing together.
// The whole pipeline holds while a finished result is stalled at the output.
// Reset clears all valid flags and loads link_length = 1280, foot_offset = 48.
module biped_leg_inverse_kinematics #(
  parameter int ANGLE_FRAC_BITS   = 13,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Request channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic signed [12:0] forward_offset_i,
  input  logic signed [12:0] height_offset_i,
  input  logic signed [12:0] side_offset_i,
  // Result channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] hip_pitch_o,
  output logic signed [15:0] knee_pitch_o,
  output logic signed [15:0] ankle_pitch_o,
  output logic signed [15:0] roll_o,
  output logic               out_of_reach_o
);
  import bli_pkg::*;

  localparam int RND_SH = 30 - ANGLE_FRAC_BITS;
  localparam logic signed [ANG_W:0] RND = (ANG_W + 1)'(1) <<< (RND_SH - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes complete in the APB access cycle; the
  // port never waits. Bit 2 of the address selects the register.
  // ---------------------------------------------------------------------------
  logic [11:0] link_q;
  logic [9:0]  offset_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q   <= LINK_RESET;
      offset_q <= OFFSET_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_LINK:   link_q   <= pwdata[11:0];
        REG_OFFSET: offset_q <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LINK:   prdata = {20'd0, link_q};
      REG_OFFSET: prdata = {22'd0, offset_q};
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flow control. Every stage moves together; the pipeline only holds when
  // the output register carries a result that the sink is stalling.
  // ---------------------------------------------------------------------------
  logic adv;
  logic out_valid_q;

  assign adv         = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------------
  // Front stage 1: select operands and form the denominator
  // d = 2L - z - offset. Crouch requests drop the forward offset and the
  // foot offset.
  // ---------------------------------------------------------------------------
  op_e                op_in;
  logic               is_foot;
  logic signed [14:0] d_calc;

  assign op_in   = op_e'(operation_i);
  assign is_foot = (op_in == OP_FOOT);
  assign d_calc  = $signed({2'b00, link_q, 1'b0}) - 15'(height_offset_i)
                   - $signed({5'd0, (is_foot ? offset_q : 10'd0)});

  logic               v1_q;
  op_e                op1_q;
  logic signed [12:0] xx1_q;
  logic signed [12:0] y1_q;
  logic signed [14:0] d1_q;
  logic [12:0]        two1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op1_q  <= op_in;
      xx1_q  <= is_foot ? forward_offset_i : 13'sd0;
      y1_q   <= side_offset_i;
      d1_q   <= d_calc;
      two1_q <= {link_q, 1'b0};
    end
  end

  // ---------------------------------------------------------------------------
  // Front stage 2: the squares. Each product is narrow and independent.
  // ---------------------------------------------------------------------------
  logic signed [25:0] xx_sq;
  logic signed [29:0] d_sq;
  logic signed [25:0] y_sq;
  logic [25:0]        two_sq;

  assign xx_sq  = xx1_q * xx1_q;
  assign d_sq   = d1_q * d1_q;
  assign y_sq   = y1_q * y1_q;
  assign two_sq = two1_q * two1_q;

  logic               v2_q;
  op_e                op2_q;
  logic signed [12:0] xx2_q;
  logic signed [12:0] y2v_q;
  logic signed [14:0] d2_q;
  logic [25:0]        xxsq_q;
  logic [27:0]        dsq_q;
  logic [25:0]        ysq_q;
  logic [25:0]        four_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op2_q  <= op1_q;
      xx2_q  <= xx1_q;
      y2v_q  <= y1_q;
      d2_q   <= d1_q;
      xxsq_q <= xx_sq[25:0];
      dsq_q  <= d_sq[27:0];
      ysq_q  <= y_sq[25:0];
      four_q <= two_sq;
    end
  end

  // ---------------------------------------------------------------------------
  // Front stage 3: reach tests and the operands of both root lanes and of
  // the CORDIC lanes. Lane A takes the squared hypotenuse, or 4L^2 - y^2 for
  // a lateral shift; lane B takes 4L^2 - H^2. An unreachable target feeds a
  // zero radicand, which makes that root zero.
  // ---------------------------------------------------------------------------
  logic [28:0] h2;
  logic        dpos;
  logic        h_in;
  logic        y_in;
  logic        is_shift;
  logic        ok_c;
  logic [27:0] rad_a_c;
  logic [27:0] rad_b_c;
  side_t       side_c;

  assign h2       = {3'd0, xxsq_q} + {1'b0, dsq_q};
  assign dpos     = (d2_q > 15'sd0);
  assign h_in     = (h2 <= {3'd0, four_q});
  assign y_in     = (ysq_q <= four_q);
  assign is_shift = (op2_q == OP_SHIFT);
  assign ok_c     = is_shift ? y_in : (dpos && h_in);

  always_comb begin
    if (is_shift) begin
      rad_a_c = y_in ? {2'd0, four_q - ysq_q} : 28'd0;
      rad_b_c = 28'd0;
    end else begin
      rad_a_c = h2[27:0];
      rad_b_c = ok_c ? 28'(four_q - h2[25:0]) : 28'd0;
    end
    side_c.op   = op2_q;
    side_c.dpos = dpos;
    side_c.ok   = ok_c;
    side_c.a0   = VEC_W'(d2_q) <<< VEC_SHIFT;
    side_c.b0   = VEC_W'(xx2_q) <<< VEC_SHIFT;
    if (y_in) begin
      side_c.b1 = VEC_W'(y2v_q) <<< VEC_SHIFT;
    end else begin
      side_c.b1 = y2v_q[12] ? -UNIT : UNIT;
    end
  end

  // ---------------------------------------------------------------------------
  // Square root chain: one cell per root bit, two lanes per step.
  // Slot 0 is the front stage 3 register.
  // ---------------------------------------------------------------------------
  logic              vs_q   [SQRT_STEPS+1];
  side_t             side_q [SQRT_STEPS+1];
  logic [RAD_W-1:0]  rad_a  [SQRT_STEPS+1];
  logic [REM_W-1:0]  rem_a  [SQRT_STEPS+1];
  logic [ROOT_W-1:0] root_a [SQRT_STEPS+1];
  logic [RAD_W-1:0]  rad_b  [SQRT_STEPS+1];
  logic [REM_W-1:0]  rem_b  [SQRT_STEPS+1];
  logic [ROOT_W-1:0] root_b [SQRT_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q[0] <= 1'b0;
    end else if (adv) begin
      vs_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_c;
      rad_a[0]  <= {rad_a_c, 32'd0};
      rad_b[0]  <= {rad_b_c, 32'd0};
      rem_a[0]  <= '0;
      rem_b[0]  <= '0;
      root_a[0] <= '0;
      root_b[0] <= '0;
    end
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    bli_sqrt_cell u_cell_a (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rad_i  (rad_a[i]),
      .rem_i  (rem_a[i]),
      .root_i (root_a[i]),
      .rad_o  (rad_a[i+1]),
      .rem_o  (rem_a[i+1]),
      .root_o (root_a[i+1])
    );

    bli_sqrt_cell u_cell_b (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rad_i  (rad_b[i]),
      .rem_i  (rem_b[i]),
      .root_i (root_b[i]),
      .rad_o  (rad_b[i+1]),
      .rem_o  (rem_b[i+1]),
      .root_o (root_b[i+1])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[i+1] <= 1'b0;
      end else if (adv) begin
        vs_q[i+1] <= vs_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        side_q[i+1] <= side_q[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // CORDIC chain. Lane 0 finds t0 = atan(x/d); lane 1 finds t1 from (H, S)
  // for placement and crouch, or the roll angle for a lateral shift.
  // ---------------------------------------------------------------------------
  logic                    vc_q [CORDIC_ITERATIONS+1];
  flag_t                   flag [CORDIC_ITERATIONS+1];
  logic signed [VEC_W-1:0] a0   [CORDIC_ITERATIONS+1];
  logic signed [VEC_W-1:0] b0   [CORDIC_ITERATIONS+1];
  logic signed [ANG_W-1:0] z0   [CORDIC_ITERATIONS+1];
  logic signed [VEC_W-1:0] a1   [CORDIC_ITERATIONS+1];
  logic signed [VEC_W-1:0] b1   [CORDIC_ITERATIONS+1];
  logic signed [ANG_W-1:0] z1   [CORDIC_ITERATIONS+1];

  assign vc_q[0]      = vs_q[SQRT_STEPS];
  assign flag[0].op   = side_q[SQRT_STEPS].op;
  assign flag[0].dpos = side_q[SQRT_STEPS].dpos;
  assign flag[0].ok   = side_q[SQRT_STEPS].ok;
  assign a0[0]        = side_q[SQRT_STEPS].a0;
  assign b0[0]        = side_q[SQRT_STEPS].b0;
  assign z0[0]        = '0;
  assign a1[0]        = VEC_W'(root_a[SQRT_STEPS]);
  assign b1[0]        = (side_q[SQRT_STEPS].op == OP_SHIFT) ? side_q[SQRT_STEPS].b1
                        : VEC_W'(root_b[SQRT_STEPS]);
  assign z1[0]        = '0;

  for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_cordic
    bli_cordic_cell #(
      .SHIFT (i),
      .ANGLE (ATAN_Q30[i])
    ) u_cell_0 (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (a0[i]),
      .b_i   (b0[i]),
      .z_i   (z0[i]),
      .a_o   (a0[i+1]),
      .b_o   (b0[i+1]),
      .z_o   (z0[i+1])
    );

    bli_cordic_cell #(
      .SHIFT (i),
      .ANGLE (ATAN_Q30[i])
    ) u_cell_1 (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (a1[i]),
      .b_i   (b1[i]),
      .z_i   (z1[i]),
      .a_o   (a1[i+1]),
      .b_o   (b1[i+1]),
      .z_o   (z1[i+1])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vc_q[i+1] <= 1'b0;
      end else if (adv) begin
        vc_q[i+1] <= vc_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        flag[i+1] <= flag[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: round both Q30 angles half up, gate the pitch angles by the
  // reach flags and form the joint angles. Results are kept to 16 bits.
  // ---------------------------------------------------------------------------
  flag_t                 fl;
  logic signed [ANG_W:0] t0r;
  logic signed [ANG_W:0] t1r;
  logic signed [ANG_W:0] t0;
  logic signed [ANG_W:0] t1;
  logic signed [ANG_W:0] hip_c;
  logic signed [ANG_W:0] knee_c;
  logic signed [ANG_W:0] ankle_c;
  logic signed [ANG_W:0] roll_c;
  logic                  oor_c;

  assign fl  = flag[CORDIC_ITERATIONS];
  assign t0r = ((ANG_W + 1)'(z0[CORDIC_ITERATIONS]) + RND) >>> RND_SH;
  assign t1r = ((ANG_W + 1)'(z1[CORDIC_ITERATIONS]) + RND) >>> RND_SH;
  assign t0  = fl.dpos ? t0r : '0;
  assign t1  = fl.ok ? t1r : '0;

  always_comb begin
    unique case (fl.op)
      OP_FOOT, OP_CROUCH: begin
        hip_c   = t0 - t1;
        knee_c  = t1 <<< 1;
        ankle_c = -(t0 + t1);
        roll_c  = '0;
        oor_c   = !fl.ok;
      end
      OP_SHIFT: begin
        hip_c   = '0;
        knee_c  = '0;
        ankle_c = '0;
        roll_c  = t1r;
        oor_c   = !fl.ok;
      end
      default: begin
        hip_c   = '0;
        knee_c  = '0;
        ankle_c = '0;
        roll_c  = '0;
        oor_c   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vc_q[CORDIC_ITERATIONS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hip_pitch_o    <= hip_c[15:0];
      knee_pitch_o   <= knee_c[15:0];
      ankle_pitch_o  <= ankle_c[15:0];
      roll_o         <= roll_c[15:0];
      out_of_reach_o <= oor_c;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bli_pkg::*;

  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;

  // One set of joint angles as the block reports it.
  typedef struct packed {
    logic signed [15:0] hip;
    logic signed [15:0] knee;
    logic signed [15:0] ankle;
    logic signed [15:0] roll;
    logic               oor;
  } pose_t;

  // Row of the directed stimulus table.  Rows with known set carry an expected
  // pose that can be read straight off the geometry; all others are predicted.
  typedef struct {
    op_e                op;
    logic signed [12:0] x;
    logic signed [12:0] z;
    logic signed [12:0] y;
    bit                 known;
    pose_t              pose;
  } vec_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         operation_i = '0;
  logic signed [12:0] forward_offset_i = '0;
  logic signed [12:0] height_offset_i = '0;
  logic signed [12:0] side_offset_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] hip_pitch_o;
  logic signed [15:0] knee_pitch_o;
  logic signed [15:0] ankle_pitch_o;
  logic signed [15:0] roll_o;
  logic               out_of_reach_o;

  biped_leg_inverse_kinematics dut (.*);

  // Our own copy of the two registers, updated whenever a write goes out.
  logic [11:0] link_mm16 = LINK_RESET;
  logic [9:0]  lift_mm16 = OFFSET_RESET;

  pose_t pending_poses[$];
  int    sender_idle_pct = 0;
  int    stall_pct = 0;
  int    hold_req = 0;
  bit    failed = 1'b0;
  longint unsigned cycles = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog: a hung pipeline or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Integer floor square root, bit by bit from the top pair of bits down.
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned res = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Vectoring rotation that drives b to zero and accumulates the angle of
  // (a, b) in Q30, then rounds half up to the Q2.13 output grid.
  function automatic longint vector_angle(longint a, longint b);
    longint acc = 0;
    longint sa;
    longint sb;
    for (int i = 0; i < 16; i++) begin
      sa = a >>> i;
      sb = b >>> i;
      if (b >= 0) begin
        a = a + sb;
        b = b - sa;
        acc = acc + longint'(ATAN_Q30[i]);
      end else begin
        a = a - sb;
        b = b + sa;
        acc = acc - longint'(ATAN_Q30[i]);
      end
    end
    return (acc + (64'sd1 <<< 16)) >>> 17;
  endfunction

  // Joint angles for one request under the current link length and lift.
  function automatic pose_t leg_angles(op_e op, longint x, longint z, longint y);
    pose_t  p = '0;
    longint span = 2 * longint'(link_mm16);
    longint reach2 = span * span;
    longint fwd;
    longint denom;
    longint hyp2;
    longint t0 = 0;
    longint t1 = 0;
    longint ra;
    longint rb;
    if (op == OP_FOOT || op == OP_CROUCH) begin
      fwd   = (op == OP_FOOT) ? x : 0;
      denom = span - z - ((op == OP_FOOT) ? longint'(lift_mm16) : 0);
      if (denom <= 0) begin
        p.oor = 1'b1;
      end else begin
        hyp2 = fwd * fwd + denom * denom;
        t0 = vector_angle(denom * 65536, fwd * 65536);
        if (hyp2 > reach2) begin
          p.oor = 1'b1;
        end else begin
          t1 = vector_angle(longint'(floor_root(longint'(hyp2) << 32)),
                            longint'(floor_root(longint'(reach2 - hyp2) << 32)));
        end
      end
      p.hip   = 16'(t0 - t1);
      p.knee  = 16'(2 * t1);
      p.ankle = 16'(-(t0 + t1));
    end else if (op == OP_SHIFT) begin
      // A shift wider than both links is clamped to a straight-out leg.
      if (y * y > reach2) begin
        p.oor = 1'b1;
        ra = 0;
        rb = (y < 0) ? -65536 : 65536;
      end else begin
        ra = longint'(floor_root(longint'(reach2 - y * y) << 32));
        rb = y * 65536;
      end
      p.roll = 16'(vector_angle(ra, rb));
    end
    return p;
  endfunction

  // Register write: setup cycle, then the access cycle that commits it.
  task automatic reg_write(logic idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_LINK) link_mm16 = val[11:0];
    else lift_mm16 = val[9:0];
  endtask

  // Offer one request, holding it until the block takes it.  The expected
  // pose is queued at the acceptance edge, so it is in place before the
  // result can appear.
  task automatic send_req(vec_t v);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid_i       <= 1'b1;
    operation_i      <= v.op;
    forward_offset_i <= v.x;
    height_offset_i  <= v.z;
    side_offset_i    <= v.y;
    do @(posedge clk_i); while (in_stall_o);
    pending_poses.push_back(v.known ? v.pose : leg_angles(v.op, v.x, v.z, v.y));
  endtask

  // Let the pipeline empty before any register changes.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [12:0] pick_pos();
    if ($urandom_range(1)) return 13'($urandom);
    return 13'(int'($urandom_range(3000)) - 1500);
  endfunction

  function automatic op_e pick_op();
    int r = $urandom_range(19);
    if (r == 0) return OP_NONE;
    return op_e'(r % 3);
  endfunction

  // Result side: random stall, long hold-offs on request, and the check of
  // every accepted result against the oldest expected pose.
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk_i) begin
    pose_t got;
    pose_t exp_p;
    if (out_valid_o && !out_stall_i) begin
      got = '{hip_pitch_o, knee_pitch_o, ankle_pitch_o, roll_o, out_of_reach_o};
      if (pending_poses.size() == 0) begin
        $display("%0t: result with no request outstanding: %p", $realtime, got);
        failed = 1'b1;
      end else begin
        exp_p = pending_poses.pop_front();
        if (got.hip !== exp_p.hip) begin
          $display("%0t: hip_pitch expected %0d got %0d", $realtime, exp_p.hip, got.hip);
          failed = 1'b1;
        end
        if (got.knee !== exp_p.knee) begin
          $display("%0t: knee_pitch expected %0d got %0d", $realtime, exp_p.knee, got.knee);
          failed = 1'b1;
        end
        if (got.ankle !== exp_p.ankle) begin
          $display("%0t: ankle_pitch expected %0d got %0d", $realtime, exp_p.ankle,
                   got.ankle);
          failed = 1'b1;
        end
        if (got.roll !== exp_p.roll) begin
          $display("%0t: roll expected %0d got %0d", $realtime, exp_p.roll, got.roll);
          failed = 1'b1;
        end
        if (got.oor !== exp_p.oor) begin
          $display("%0t: out_of_reach expected %0b got %0b", $realtime, exp_p.oor, got.oor);
          failed = 1'b1;
        end
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    vec_t  dir[$];
    vec_t  v;
    int    lens[4] = '{16, 4095, 700, 2000};
    int    lifts[4] = '{0, 1023, 500, 48};
    int    sidle[4] = '{0, 60, 0, 20};
    int    ridle[4] = '{0, 0, 60, 20};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset link length (2L = 2560) and lift of 48.
    // A foot at or above the hip line, or an unused operation, yields zeros.
    dir.push_back('{OP_FOOT,    0,     0,     0,     0, '0});
    dir.push_back('{OP_FOOT,    4095,  -4096, 0,     0, '0});
    dir.push_back('{OP_FOOT,    -4096, 4095,  0,     1, '{0, 0, 0, 0, 1}});
    dir.push_back('{OP_FOOT,    0,     2512,  0,     1, '{0, 0, 0, 0, 1}});
    dir.push_back('{OP_FOOT,    0,     2511,  0,     0, '0});
    dir.push_back('{OP_FOOT,    1000,  500,   4095,  0, '0});
    dir.push_back('{OP_FOOT,    -1,    -1,    -1,    0, '0});
    dir.push_back('{OP_FOOT,    -4096, 0,     -4096, 0, '0});
    dir.push_back('{OP_CROUCH,  0,     4095,  0,     1, '{0, 0, 0, 0, 1}});
    dir.push_back('{OP_CROUCH,  0,     2560,  0,     1, '{0, 0, 0, 0, 1}});
    dir.push_back('{OP_CROUCH,  0,     0,     0,     0, '0});
    dir.push_back('{OP_CROUCH,  0,     -4096, 0,     0, '0});
    dir.push_back('{OP_CROUCH,  4095,  100,   -4096, 0, '0});
    dir.push_back('{OP_SHIFT,   0,     0,     0,     0, '0});
    dir.push_back('{OP_SHIFT,   0,     0,     2560,  0, '0});
    dir.push_back('{OP_SHIFT,   0,     0,     -2560, 0, '0});
    dir.push_back('{OP_SHIFT,   0,     0,     2561,  0, '0});
    dir.push_back('{OP_SHIFT,   4095,  4095,  -4096, 0, '0});
    dir.push_back('{OP_SHIFT,   -4096, -4096, 4095,  0, '0});
    dir.push_back('{OP_NONE,    4095,  4095,  4095,  1, '0});
    dir.push_back('{OP_NONE,    -4096, -4096, -4096, 1, '0});
    foreach (dir[i]) send_req(dir[i]);
    drain();

    // A zero link length: every crouch sits on the hip line, and a zero
    // shift takes the degenerate path of the rotation.
    reg_write(REG_LINK, 32'd0);
    reg_write(REG_OFFSET, 32'd0);
    send_req('{OP_SHIFT,  0, 0, 0, 0, '0});
    send_req('{OP_CROUCH, 0, 0, 0, 1, '{0, 0, 0, 0, 1}});
    send_req('{OP_SHIFT,  0, 0, 1, 0, '0});
    drain();

    // Random part: one phase per register setting and idling pattern.
    for (int ph = 0; ph < 4; ph++) begin
      reg_write(REG_LINK, 32'(lens[ph]));
      reg_write(REG_OFFSET, 32'(lifts[ph]));
      sender_idle_pct = sidle[ph];
      stall_pct = ridle[ph];
      for (int n = 0; n < 150; n++) begin
        // Fill the pipeline against a long output hold-off once.
        if (ph == 0 && n == 20) hold_req = hold_req + 1;
        v.op = pick_op();
        v.x = pick_pos();
        v.z = pick_pos();
        v.y = pick_pos();
        v.known = 1'b0;
        v.pose = '0;
        send_req(v);
      end
      drain();
    end

    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
